@@ design/fprt_pkg.sv @@
// Package: shared constants, codes and types of the firmware page receive tracker.
`timescale 1ns / 1ps
package fprt_pkg;

	// Sector geometry. The sector size is a power of two set by its shift.
	localparam int unsigned SECTOR_SHIFT = 12;
	localparam int unsigned SECTOR_BYTES = 1 << SECTOR_SHIFT;
	localparam int unsigned CHUNK_SHIFT  = 6;
	localparam int unsigned MAP_BITS     = 64;
	localparam int unsigned IDX_W        = $clog2(MAP_BITS);

	// Field widths.
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned ADDR_W   = 32;
	localparam int unsigned LEN_W    = 7;
	localparam int unsigned STATUS_W = 3;

	localparam logic [LEN_W-1:0] MIN_PACKET = LEN_W'(7);

	// Packet types on the kind field.
	localparam logic [KIND_W-1:0] KIND_START    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DATA     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PAGE_END = 2'd2;
	localparam logic [KIND_W-1:0] KIND_VERIFY   = 2'd3;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_NEW       = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_OLDER     = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_SHORT     = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_CONTROL   = 3'd4;

	// Command queue between the front and back parts.
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	typedef enum logic [2:0] {
		OP_SHORT,
		OP_START,
		OP_DATA,
		OP_PAGE_END,
		OP_VERIFY
	} op_t;

	// A classified request as the front part hands it to the back part.
	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] page;   // sector base for data, raw offset for page end
		logic [IDX_W-1:0]  idx;    // chunk index within the sector
		logic              mark;   // non-empty chunk, sets its map bit
	} cmd_t;

	// One result item.
	typedef struct packed {
		logic                erase_request;
		logic [ADDR_W-1:0]   erase_address;
		logic                write_request;
		logic                report_valid;
		logic [ADDR_W-1:0]   report_page;
		logic [MAP_BITS-1:0] report_map;
		logic [STATUS_W-1:0] status;
	} res_t;

endpackage

@@ design/fprt_front.sv @@
// Front part: classifies an incoming request and pushes it into the command queue.
`timescale 1ns / 1ps
module fprt_front (
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [fprt_pkg::KIND_W-1:0]   kind,
	input  logic [fprt_pkg::ADDR_W-1:0]   offset,
	input  logic [fprt_pkg::LEN_W-1:0]    payload_length,
	input  logic [fprt_pkg::LEN_W-1:0]    packet_bytes,
	input  logic                          queue_full,
	output logic                          push,
	output fprt_pkg::cmd_t                cmd
);
	import fprt_pkg::*;

	logic [ADDR_W-1:0] sector_base;
	logic [IDX_W-1:0]  chunk_sel;

	// Sector base and chunk index are plain bit fields of the offset.
	assign sector_base = (offset >> SECTOR_SHIFT) << SECTOR_SHIFT;
	assign chunk_sel   = IDX_W'(offset[SECTOR_SHIFT-1:0] >> CHUNK_SHIFT);

	assign in_ready = !queue_full;
	assign push     = in_valid && !queue_full;

	always_comb begin
		cmd.page = '0;
		cmd.idx  = chunk_sel;
		cmd.mark = (payload_length != '0);
		cmd.op   = OP_SHORT;
		if (packet_bytes >= MIN_PACKET) begin
			case (kind)
				KIND_START: begin
					cmd.op = OP_START;
				end
				KIND_DATA: begin
					cmd.op   = OP_DATA;
					cmd.page = sector_base;
				end
				KIND_PAGE_END: begin
					cmd.op   = OP_PAGE_END;
					cmd.page = offset;
				end
				KIND_VERIFY: begin
					cmd.op = OP_VERIFY;
				end
				default: begin
					cmd.op = OP_SHORT;
				end
			endcase
		end
	end

endmodule

@@ design/fprt_queue.sv @@
// Command queue: a short first-in first-out store between the front and back parts.
`timescale 1ns / 1ps
module fprt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fprt_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output fprt_pkg::cmd_t pop_cmd
);
	import fprt_pkg::*;

	localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full      = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

@@ design/fprt_back.sv @@
// Back part: holds the sector tracking state, executes commands and registers the result.
`timescale 1ns / 1ps
module fprt_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  fprt_pkg::cmd_t cmd,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output fprt_pkg::res_t res
);
	import fprt_pkg::*;

	logic                page_valid_q;
	logic [ADDR_W-1:0]   current_page_q;
	logic [MAP_BITS-1:0] chunk_map_q;
	logic                first_erased_q;
	logic                out_valid_q;
	res_t                res_q;

	logic                page_valid_d;
	logic [ADDR_W-1:0]   current_page_d;
	logic [MAP_BITS-1:0] chunk_map_d;
	logic                first_erased_d;
	res_t                res_d;
	logic                older;

	assign pop       = cmd_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_comb begin
		page_valid_d   = page_valid_q;
		current_page_d = current_page_q;
		chunk_map_d    = chunk_map_q;
		first_erased_d = first_erased_q;
		older          = 1'b0;
		res_d          = '0;
		res_d.status   = STATUS_CONTROL;
		case (cmd.op)
			OP_SHORT: begin
				res_d.status = STATUS_SHORT;
			end
			OP_START: begin
				page_valid_d        = 1'b0;
				current_page_d      = '0;
				chunk_map_d         = '0;
				first_erased_d      = 1'b1;
				res_d.erase_request = 1'b1;
			end
			OP_DATA: begin
				if (!page_valid_q) begin
					page_valid_d   = 1'b1;
					current_page_d = cmd.page;
					chunk_map_d    = '0;
					if (cmd.page == '0) begin
						if (!first_erased_q) begin
							res_d.erase_request = 1'b1;
							first_erased_d      = 1'b1;
						end
					end else begin
						res_d.erase_request = 1'b1;
						res_d.erase_address = cmd.page;
					end
				end else if (cmd.page > current_page_q) begin
					current_page_d      = cmd.page;
					chunk_map_d         = '0;
					res_d.erase_request = 1'b1;
					res_d.erase_address = cmd.page;
				end else if (cmd.page < current_page_q) begin
					older = 1'b1;
				end
				if (older) begin
					res_d.status = STATUS_OLDER;
				end else if (chunk_map_d[cmd.idx]) begin
					res_d.status = STATUS_DUPLICATE;
				end else begin
					if (cmd.mark) begin
						chunk_map_d[cmd.idx] = 1'b1;
					end
					res_d.write_request = 1'b1;
					res_d.status        = STATUS_NEW;
				end
			end
			OP_PAGE_END: begin
				if (page_valid_q && cmd.page == current_page_q) begin
					res_d.report_valid = 1'b1;
				end else if (!page_valid_q && cmd.page == '0) begin
					page_valid_d       = 1'b1;
					current_page_d     = '0;
					chunk_map_d        = '0;
					res_d.report_valid = 1'b1;
				end else if (page_valid_q && cmd.page > current_page_q) begin
					current_page_d     = cmd.page;
					chunk_map_d        = '0;
					res_d.report_valid = 1'b1;
				end
				if (res_d.report_valid) begin
					res_d.report_page = current_page_d;
					res_d.report_map  = chunk_map_d;
				end
			end
			OP_VERIFY: begin
				if (page_valid_q) begin
					res_d.report_valid = 1'b1;
					res_d.report_page  = current_page_q;
					res_d.report_map   = chunk_map_q;
				end
				page_valid_d = 1'b0;
			end
			default: begin
				res_d.status = STATUS_CONTROL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_valid_q   <= 1'b0;
			current_page_q <= '0;
			chunk_map_q    <= '0;
			first_erased_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (pop) begin
				page_valid_q   <= page_valid_d;
				current_page_q <= current_page_d;
				chunk_map_q    <= chunk_map_d;
				first_erased_q <= first_erased_d;
				out_valid_q    <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

endmodule

@@ design/firmware_page_receive_tracker_core.sv @@
// Top level of the firmware page receive tracker.
//
//  Channel   Handshake               Payload
//  --------  ----------------------  ------------------------------------------------
//  input     in_valid / in_ready     kind, offset, payload_length, packet_bytes
//  result    out_valid / out_ready   erase_request, erase_address, write_request,
//                                    report_valid, report_page, report_map, status
//
// One request is taken per cycle while the queue is not full, and gives exactly one
// result: it is held in the command queue, then in the back part's result register.
// The back part's update of the sector state is the single loop that sets the rate;
// it retires one command per cycle whenever the result register is free or draining.
// Reset (arst_n low) empties the queue, drops any pending result and clears the
// tracker: no current sector, empty chunk map, sector 0 not yet erased.
// A stalled result holds the back part; requests keep being taken until the queue
// fills, so in_ready only falls after two requests pile up behind a stalled result.
`timescale 1ns / 1ps
module firmware_page_receive_tracker_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [fprt_pkg::KIND_W-1:0]     kind,
	input  logic [fprt_pkg::ADDR_W-1:0]     offset,
	input  logic [fprt_pkg::LEN_W-1:0]      payload_length,
	input  logic [fprt_pkg::LEN_W-1:0]      packet_bytes,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            erase_request,
	output logic [fprt_pkg::ADDR_W-1:0]     erase_address,
	output logic                            write_request,
	output logic                            report_valid,
	output logic [fprt_pkg::ADDR_W-1:0]     report_page,
	output logic [fprt_pkg::MAP_BITS-1:0]   report_map,
	output logic [fprt_pkg::STATUS_W-1:0]   status
);
	import fprt_pkg::*;

	// Classified request from the front part into the queue.
	logic push;
	logic queue_full;
	cmd_t push_cmd;

	// Head of the queue as seen by the back part.
	logic queue_not_empty;
	logic pop;
	cmd_t pop_cmd;

	res_t res;

	// The front part decides the packet type, drops short packets to a status-only
	// command, and splits a data offset into its sector base and chunk index.
	fprt_front u_front (
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.offset         (offset),
		.payload_length (payload_length),
		.packet_bytes   (packet_bytes),
		.queue_full     (queue_full),
		.push           (push),
		.cmd            (push_cmd)
	);

	// The queue lets the front keep taking requests while the result side stalls.
	fprt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (queue_not_empty),
		.pop_cmd   (pop_cmd)
	);

	// The back part owns the current sector, its chunk map and the sector 0 erase
	// flag, and registers one result per command it retires.
	fprt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (queue_not_empty),
		.cmd       (pop_cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign erase_request = res.erase_request;
	assign erase_address = res.erase_address;
	assign write_request = res.write_request;
	assign report_valid  = res.report_valid;
	assign report_page   = res.report_page;
	assign report_map    = res.report_map;
	assign status        = res.status;

endmodule

@@ verif/firmware_page_receive_tracker_core_tb.sv @@
// Testbench of the firmware page receive tracker: random and directed packets.
`timescale 1ns / 1ps
module firmware_page_receive_tracker_core_tb;
	import fprt_pkg::*;

	// One received packet as the sender offers it.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] offset;
		logic [LEN_W-1:0]  payload_length;
		logic [LEN_W-1:0]  packet_bytes;
	} rx_packet_t;

	// Sector tracker predictor together with the queue of results it expects.
	class tracker_scoreboard;
		res_t                expected_q[$];
		bit                  page_valid;
		logic [ADDR_W-1:0]   current_page;
		logic [MAP_BITS-1:0] chunk_map;
		bit                  sector0_erased;
		int                  errors;

		function new();
			page_valid     = 1'b0;
			current_page   = '0;
			chunk_map      = '0;
			sector0_erased = 1'b0;
			errors         = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Works out the result of an accepted request and updates the tracker copy.
		function void note_request(rx_packet_t p);
			res_t              r;
			logic [ADDR_W-1:0] in_sector;
			logic [ADDR_W-1:0] base;
			int unsigned       idx;
			bit                older;
			bit                report;
			r      = '0;
			r.status = STATUS_CONTROL;
			older  = 1'b0;
			report = 1'b0;
			if (p.packet_bytes < MIN_PACKET) begin
				r.status = STATUS_SHORT;
			end else begin
				case (p.kind)
					KIND_START: begin
						page_valid     = 1'b0;
						current_page   = '0;
						chunk_map      = '0;
						sector0_erased = 1'b1;
						r.erase_request = 1'b1;
					end
					KIND_DATA: begin
						in_sector = p.offset & ADDR_W'(SECTOR_BYTES - 1);
						base      = p.offset - in_sector;
						idx       = in_sector >> CHUNK_SHIFT;
						if (!page_valid) begin
							page_valid   = 1'b1;
							current_page = base;
							chunk_map    = '0;
							if (base == '0) begin
								if (!sector0_erased) begin
									r.erase_request = 1'b1;
									sector0_erased  = 1'b1;
								end
							end else begin
								r.erase_request = 1'b1;
								r.erase_address = base;
							end
						end else if (base > current_page) begin
							current_page    = base;
							chunk_map       = '0;
							r.erase_request = 1'b1;
							r.erase_address = base;
						end else if (base < current_page) begin
							older = 1'b1;
						end
						if (older) begin
							r.status = STATUS_OLDER;
						end else if (idx < MAP_BITS && chunk_map[idx]) begin
							r.status = STATUS_DUPLICATE;
						end else begin
							if (p.payload_length != '0 && idx < MAP_BITS)
								chunk_map[idx] = 1'b1;
							r.write_request = 1'b1;
							r.status        = STATUS_NEW;
						end
					end
					KIND_PAGE_END: begin
						if (page_valid && p.offset == current_page) begin
							report = 1'b1;
						end else if (!page_valid && p.offset == '0) begin
							page_valid   = 1'b1;
							current_page = '0;
							chunk_map    = '0;
							report       = 1'b1;
						end else if (page_valid && p.offset > current_page) begin
							current_page = p.offset;
							chunk_map    = '0;
							report       = 1'b1;
						end
						if (report) begin
							r.report_valid = 1'b1;
							r.report_page  = current_page;
							r.report_map   = chunk_map;
						end
					end
					default: begin
						if (page_valid) begin
							r.report_valid = 1'b1;
							r.report_page  = current_page;
							r.report_map   = chunk_map;
						end
						page_valid = 1'b0;
					end
				endcase
			end
			expected_q.push_back(r);
		endfunction

		function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
			if (act_v !== exp_v) begin
				$error("%s: expected %h, got %h", name, exp_v, act_v);
				errors++;
			end
		endfunction

		// Compares an accepted result with the oldest outstanding expectation.
		function void check_result(res_t got);
			res_t exp_r;
			if (expected_q.size() == 0) begin
				$error("result arrived with no request outstanding");
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			compare_field("erase_request", exp_r.erase_request, got.erase_request);
			compare_field("erase_address", exp_r.erase_address, got.erase_address);
			compare_field("write_request", exp_r.write_request, got.write_request);
			compare_field("report_valid", exp_r.report_valid, got.report_valid);
			compare_field("report_page", exp_r.report_page, got.report_page);
			compare_field("report_map", exp_r.report_map, got.report_map);
			compare_field("status", exp_r.status, got.status);
		endfunction
	endclass

	localparam int RANDOM_REQUESTS = 1500;
	localparam int LONG_HOLD       = 300;
	localparam int CYCLE_LIMIT     = 400000;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [KIND_W-1:0]   kind;
	logic [ADDR_W-1:0]   offset;
	logic [LEN_W-1:0]    payload_length;
	logic [LEN_W-1:0]    packet_bytes;
	logic                out_valid;
	logic                out_ready;
	logic                erase_request;
	logic [ADDR_W-1:0]   erase_address;
	logic                write_request;
	logic                report_valid;
	logic [ADDR_W-1:0]   report_page;
	logic [MAP_BITS-1:0] report_map;
	logic [STATUS_W-1:0] status;

	tracker_scoreboard tracker_sb;

	// Idle pattern shared by both sides: 0 never waits, 1 draws a random wait before
	// every request or result, 2 waits only now and then.
	int          idle_mode;
	bit          hold_off_request;
	int unsigned cycle_count;

	// Sector that the random data walk is currently filling.
	logic [ADDR_W-1:0] walk_page;

	firmware_page_receive_tracker_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.offset         (offset),
		.payload_length (payload_length),
		.packet_bytes   (packet_bytes),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.erase_request  (erase_request),
		.erase_address  (erase_address),
		.write_request  (write_request),
		.report_valid   (report_valid),
		.report_page    (report_page),
		.report_map     (report_map),
		.status         (status)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// The watchdog ends a run that has hung, whatever the reason.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic int draw_wait();
		case (idle_mode)
			0: return 0;
			1: return $urandom_range(0, 17);
			default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
		endcase
	endfunction

	function automatic rx_packet_t make_packet(logic [KIND_W-1:0] k, logic [ADDR_W-1:0] off,
		logic [LEN_W-1:0] plen, logic [LEN_W-1:0] pbytes);
		rx_packet_t p;
		p.kind           = k;
		p.offset         = off;
		p.payload_length = plen;
		p.packet_bytes   = pbytes;
		return p;
	endfunction

	// Offers one request and waits for the block to take it. The task is entered
	// and left at a falling edge; when there is no gap, in_valid simply stays high
	// so that it never sees two assignments in one time step.
	task automatic send_request(input rx_packet_t p);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid       <= 1'b1;
		kind           <= p.kind;
		offset         <= p.offset;
		payload_length <= p.payload_length;
		packet_bytes   <= p.packet_bytes;
		do @(posedge clk); while (!in_ready);
		tracker_sb.note_request(p);
		@(negedge clk);
	endtask

	// Holds the sender back until every outstanding result has come out.
	task automatic wait_for_drain();
		while (tracker_sb.pending() != 0) @(negedge clk);
	endtask

	// Mostly well-formed traffic: data walking forward through sectors with the odd
	// step back, page ends near the current sector, verifies and the rare start.
	// A small share is short packets or wholly random requests.
	function automatic rx_packet_t random_packet();
		rx_packet_t  p;
		int unsigned sel;
		int unsigned step;
		p.packet_bytes   = ($urandom_range(0, 99) < 6) ? LEN_W'($urandom_range(0, 6))
			: LEN_W'($urandom_range(7, 127));
		p.payload_length = ($urandom_range(0, 7) == 0) ? '0 : LEN_W'($urandom_range(1, 64));
		p.offset         = '0;
		sel = $urandom_range(0, 99);
		if (sel < 4) begin
			p.kind    = KIND_START;
			p.offset  = $urandom;
			walk_page = '0;
		end else if (sel < 70) begin
			p.kind = KIND_DATA;
			step   = $urandom_range(0, 99);
			if (step < 8 && walk_page >= SECTOR_BYTES)
				walk_page = walk_page - SECTOR_BYTES;
			else if (step < 18)
				walk_page = walk_page + SECTOR_BYTES;
			else if (step < 20)
				walk_page = walk_page + SECTOR_BYTES * $urandom_range(2, 5);
			else if (step == 20)
				walk_page = $urandom & ~ADDR_W'(SECTOR_BYTES - 1);
			p.offset = walk_page + ($urandom_range(0, 63) << CHUNK_SHIFT) + $urandom_range(0, 63);
		end else if (sel < 84) begin
			p.kind = KIND_PAGE_END;
			case ($urandom_range(0, 4))
				0, 1: p.offset = walk_page;
				2: p.offset = walk_page + SECTOR_BYTES;
				3: p.offset = '0;
				default: p.offset = $urandom;
			endcase
		end else if (sel < 94) begin
			p.kind   = KIND_VERIFY;
			p.offset = $urandom;
		end else begin
			p.kind           = KIND_W'($urandom_range(0, 3));
			p.offset         = $urandom;
			p.payload_length = LEN_W'($urandom_range(0, 64));
		end
		return p;
	endfunction

	// Result side: for every result it draws a stall, or the long hold-off when one
	// has been asked for, and then waits with out_ready high for the block to offer.
	initial begin
		int   stall;
		res_t got;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = draw_wait();
			if (hold_off_request) begin
				stall            = LONG_HOLD;
				hold_off_request = 1'b0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got.erase_request = erase_request;
			got.erase_address = erase_address;
			got.write_request = write_request;
			got.report_valid  = report_valid;
			got.report_page   = report_page;
			got.report_map    = report_map;
			got.status        = status;
			tracker_sb.check_result(got);
			@(negedge clk);
		end
	end

	// Request side: reset, a directed pass over the special cases, then the random
	// traffic with its changing idle patterns and the two pressure phases.
	initial begin
		rx_packet_t directed_q[$];
		tracker_sb       = new();
		cycle_count      = 0;
		idle_mode        = 0;
		hold_off_request = 1'b0;
		walk_page        = '0;
		arst_n           = 1'b0;
		in_valid         = 1'b0;
		kind             = '0;
		offset           = '0;
		payload_length   = '0;
		packet_bytes     = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// First data after reset lands in sector 0, which has not been erased yet.
		directed_q.push_back(make_packet(KIND_DATA, 32'h0000_0040, 7'd64, 7'd127));
		// The same chunk again is a duplicate and is not written.
		directed_q.push_back(make_packet(KIND_DATA, 32'h0000_0040, 7'd10, 7'd7));
		// An empty chunk is written but leaves its map bit clear, so it can come again.
		directed_q.push_back(make_packet(KIND_DATA, 32'h0000_0000, 7'd0, 7'd20));
		directed_q.push_back(make_packet(KIND_DATA, 32'h0000_0000, 7'd5, 7'd20));
		directed_q.push_back(make_packet(KIND_PAGE_END, 32'h0000_0000, 7'd0, 7'd9));
		// Short packets change nothing, whatever their kind.
		directed_q.push_back(make_packet(KIND_DATA, 32'h0000_1000, 7'd64, 7'd6));
		directed_q.push_back(make_packet(KIND_START, 32'hFFFF_FFFF, 7'd0, 7'd0));
		// A newer sector is erased on entry; the last chunk of a sector is index 63.
		directed_q.push_back(make_packet(KIND_DATA, 32'h0000_2FC0, 7'd64, 7'd70));
		// Data for an older sector is ignored.
		directed_q.push_back(make_packet(KIND_DATA, 32'h0000_1040, 7'd33, 7'd70));
		// A page end for an older sector gives no report; one above moves the tracker.
		directed_q.push_back(make_packet(KIND_PAGE_END, 32'h0000_1000, 7'd0, 7'd8));
		directed_q.push_back(make_packet(KIND_PAGE_END, 32'h0000_5000, 7'd0, 7'd8));
		// Verify reports and drops the current sector; a second one reports nothing.
		directed_q.push_back(make_packet(KIND_VERIFY, 32'h1234_5678, 7'd0, 7'd7));
		directed_q.push_back(make_packet(KIND_VERIFY, 32'h0000_0000, 7'd0, 7'd7));
		// With no current sector only a page end for offset 0 is taken up.
		directed_q.push_back(make_packet(KIND_PAGE_END, 32'h0000_0010, 7'd0, 7'd7));
		// Sector 0 entered again without a start: it has already been erased.
		directed_q.push_back(make_packet(KIND_DATA, 32'h0000_0000, 7'd1, 7'd7));
		directed_q.push_back(make_packet(KIND_VERIFY, 32'h0000_0000, 7'd0, 7'd7));
		directed_q.push_back(make_packet(KIND_PAGE_END, 32'h0000_0000, 7'd0, 7'd7));
		directed_q.push_back(make_packet(KIND_DATA, 32'h0000_0080, 7'd64, 7'd127));
		// Start erases sector 0 itself, so the next sector 0 entry does not.
		directed_q.push_back(make_packet(KIND_START, 32'h0000_0000, 7'd0, 7'd7));
		directed_q.push_back(make_packet(KIND_DATA, 32'h0000_0000, 7'd64, 7'd7));
		// The very top of the address space.
		directed_q.push_back(make_packet(KIND_DATA, 32'hFFFF_FFFF, 7'd64, 7'd127));
		directed_q.push_back(make_packet(KIND_PAGE_END, 32'hFFFF_FFFF, 7'd0, 7'd127));
		directed_q.push_back(make_packet(KIND_VERIFY, 32'hFFFF_FFFF, 7'd64, 7'd127));
		directed_q.push_back(make_packet(KIND_VERIFY, 32'h0000_0000, 7'd0, 7'd6));
		directed_q.push_back(make_packet(KIND_START, 32'hA5A5_5A5A, 7'd64, 7'd100));
		foreach (directed_q[i]) send_request(directed_q[i]);
		walk_page = '0;

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 100 == 0)
				idle_mode = $urandom_range(0, 2);
			// The result side holds off for a long while and the sender keeps pushing,
			// so the queue fills and in_ready has to fall.
			if (n == 500) begin
				idle_mode        = 0;
				hold_off_request = 1'b1;
			end
			// Here the sender stops until the block has emptied completely.
			if (n == 1000) begin
				in_valid <= 1'b0;
				wait_for_drain();
				@(negedge clk);
			end
			send_request(random_packet());
		end
		in_valid <= 1'b0;

		wait_for_drain();
		repeat (10) @(negedge clk);
		if (tracker_sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ firmware_page_receive_tracker_core.f @@
design/fprt_pkg.sv
design/fprt_front.sv
design/fprt_queue.sv
design/fprt_back.sv
design/firmware_page_receive_tracker_core.sv
verif/firmware_page_receive_tracker_core_tb.sv
